// ===== hdl/rsenc_pkg.sv =====
// Shared types, constants and GF(256) helpers for the Reed-Solomon check-byte encoder.
// No dependencies; imported by rsenc_gen and reed_solomon_ec_encoder.
package rsenc_pkg;

	localparam int MAX_CHECK_BYTES = 32;
	localparam int CNT_W           = $clog2(MAX_CHECK_BYTES + 1);
	localparam logic [7:0] GF_POLY_LO = 8'h1D;   // x^8 + x^4 + x^3 + x^2 + 1, top bit implied
	localparam logic [CNT_W-1:0] EC_RESET = CNT_W'(10);
	localparam logic [CNT_W-1:0] EC_MAX   = CNT_W'(MAX_CHECK_BYTES);

	typedef logic [MAX_CHECK_BYTES-1:0][7:0] byte_vec_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       block_end;
	} item_t;

	typedef struct packed {
		logic [7:0] check_byte;
		logic       last_check;
	} result_t;

	typedef struct packed {
		logic             busy;
		logic [CNT_W-1:0] n;
	} gen_status_t;

	// multiply by alpha in GF(256)
	function automatic logic [7:0] gf_xtime(input logic [7:0] a);
		gf_xtime = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY_LO : 8'h00);
	endfunction

	// shift-and-add GF(256) multiply
	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] x;
		logic [7:0] acc;
		x   = a;
		acc = 8'h00;
		for (int k = 0; k < 8; k++) begin
			if (b[k]) begin
				acc = acc ^ x;
			end
			x = gf_xtime(x);
		end
		gf_mul = acc;
	endfunction

	// clamp the programmed count to 1 .. MAX_CHECK_BYTES
	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
		if (c == '0) begin
			eff_count = CNT_W'(1);
		end else if (c > EC_MAX) begin
			eff_count = EC_MAX;
		end else begin
			eff_count = c;
		end
	endfunction

endpackage

// ===== hdl/rsenc_gen.sv =====
// Check-count register and generator polynomial sequencer: one (x + alpha^i) factor per cycle.
// Depends on rsenc_pkg.
module rsenc_gen import rsenc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [CNT_W-1:0]  cfg_wr_data,
	output gen_status_t       status,
	output byte_vec_t         coef
);

	logic [CNT_W-1:0] ec_q;
	logic [CNT_W-1:0] step_q;
	logic [CNT_W-1:0] n;
	logic [7:0]       root_q;
	logic             busy_q;
	byte_vec_t        coef_q;
	byte_vec_t        coef_next;

	assign n = eff_count(ec_q);

	// multiply the running product by (x + root): every coefficient gains its upper neighbor * root
	always_comb begin
		for (int k = 0; k < MAX_CHECK_BYTES; k++) begin
			coef_next[k] = coef_q[k] ^ gf_mul((k == 0) ? 8'h01
				: coef_q[(k + MAX_CHECK_BYTES - 1) % MAX_CHECK_BYTES], root_q);
		end
	end

	// restart on reset or on a count write, advance one root per cycle until n roots are in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ec_q   <= EC_RESET;
			busy_q <= 1'b1;
			step_q <= '0;
			root_q <= 8'h01;
			coef_q <= '0;
		end else if (cfg_wr_en) begin
			ec_q   <= cfg_wr_data;
			busy_q <= 1'b1;
			step_q <= '0;
			root_q <= 8'h01;
			coef_q <= '0;
		end else if (busy_q) begin
			coef_q <= coef_next;
			root_q <= gf_xtime(root_q);
			step_q <= CNT_W'(step_q + 1'b1);
			if (CNT_W'(step_q + 1'b1) == n) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign status.busy = busy_q;
	assign status.n    = n;
	assign coef        = coef_q;

endmodule

// ===== hdl/reed_solomon_ec_encoder.sv =====
// Reed-Solomon (GF(256), 0x11D) systematic check-byte encoder, top level.
// A block's first check byte is offered once its block-end beat has left the input register for the emit buffer.
// Throughput: one data byte per cycle; a block-end beat waits in the input register until the
// previous block's n check bytes have drained from the emit buffer (one per cycle with result_ready high).
// Reset (arst_n low, async): count 10, remainder cleared; the generator sequencer then steps
// through its n roots (also after each count write) with item_ready low.
module reed_solomon_ec_encoder import rsenc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  item_t             item,
	output logic              result_valid,
	input  logic              result_ready,
	output result_t           result,
	input  logic              cfg_wr_en,
	input  logic [CNT_W-1:0]  cfg_wr_data
);

	gen_status_t      gen;
	byte_vec_t        coef;
	logic             valid_s1;
	item_t            item_s1;
	byte_vec_t        rem_q;
	byte_vec_t        rem_next;
	byte_vec_t        emit_q;
	logic [CNT_W-1:0] emit_left_q;
	logic [7:0]       factor;
	logic             advance;
	logic             emit_busy;
	logic             item_beat;
	logic             result_beat;

	rsenc_gen u_gen (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.status      (gen),
		.coef        (coef)
	);

	assign emit_busy   = (emit_left_q != '0);
	assign advance     = valid_s1 && !(item_s1.block_end && emit_busy);
	assign item_ready  = !gen.busy && (!valid_s1 || advance);
	assign item_beat   = item_valid && item_ready;
	assign result_beat = result_valid && result_ready;

	// division step: shift toward the front, add feedback times each generator coefficient
	always_comb begin
		factor = item_s1.data_byte ^ rem_q[0];
		for (int i = 0; i < MAX_CHECK_BYTES; i++) begin
			rem_next[i] = gf_mul(coef[i], factor);
			if ((i + 1 < MAX_CHECK_BYTES) && (CNT_W'(i + 1) < gen.n)) begin
				rem_next[i] = rem_next[i] ^ rem_q[(i + 1) % MAX_CHECK_BYTES];
			end
		end
	end

	// hold the input beat until the division register can take it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_beat) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_beat) begin
			item_s1 <= item;
		end
	end

	// update the remainder; on block end hand it to the emit buffer and clear; a count write also clears it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (cfg_wr_en) begin
			rem_q <= '0;
		end else if (advance) begin
			rem_q <= item_s1.block_end ? '0 : rem_next;
		end
	end

	// drain check bytes highest-order first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_left_q <= '0;
		end else if (advance && item_s1.block_end) begin
			emit_left_q <= gen.n;
		end else if (result_beat) begin
			emit_left_q <= CNT_W'(emit_left_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.block_end) begin
			emit_q <= rem_next;
		end else if (result_beat) begin
			emit_q <= {8'h00, emit_q[MAX_CHECK_BYTES-1:1]};
		end
	end

	assign result_valid      = emit_busy;
	assign result.check_byte = emit_q[0];
	assign result.last_check = (emit_left_q == CNT_W'(1));

	// no data beat is taken while the generator is being rebuilt
	a_no_item_while_deriving: assert property (@(posedge clk) disable iff (!arst_n)
		gen.busy |-> !item_ready)
		else $error("item_ready high during generator derivation");

	// the final check beat empties the emit buffer
	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(result_beat && result.last_check) |=> !result_valid)
		else $error("result still valid after last check byte");

	// a block end never overwrites a block still draining
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && item_s1.block_end && emit_busy) |-> !advance)
		else $error("block end advanced while check bytes pending");

endmodule
